// ----- src/sentence_select_extract_unit_assert.svh -----
// Assertion macros for the sentence select and extract unit.
// Included by the top-level module, which carries the concurrent assertions; no other dependencies.
`ifndef SENTENCE_SELECT_EXTRACT_UNIT_ASSERT_SVH
`define SENTENCE_SELECT_EXTRACT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define SSX_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ssx assertion failed");
// Expression must never be true at a rising clock edge outside reset.
`define SSX_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("ssx forbidden condition seen");
`else
`define SSX_ASSERT(label, clk, rst_n, prop)
`define SSX_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ----- src/ssx_pkg.sv -----
// Package for the sentence select and extract unit: widths, codes and shared types.
// Has no dependencies; every other source file but the assertion header uses it.
package ssx_pkg;

  // Width of the finished-sentence counter and of the emitted-byte counter.
  localparam int COUNT_WIDTH  = 16;
  localparam int LENGTH_WIDTH = 12;

  localparam int CH_W         = 8;
  localparam int INDEX_W      = 16;
  localparam int CAP_W        = 13;
  localparam int STATUS_W     = 2;
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 16;

  // Comparison widths wide enough for both operands.
  localparam int LIMIT_W = (LENGTH_WIDTH > CAP_W) ? LENGTH_WIDTH : CAP_W;
  localparam int SEL_W   = (COUNT_WIDTH > INDEX_W) ? COUNT_WIDTH : INDEX_W;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_SENTENCE_INDEX = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_CAPACITY   = 1'b1;

  localparam logic [INDEX_W-1:0] INDEX_RESET = '0;
  localparam logic [CAP_W-1:0]   CAP_RESET   = 13'd256;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_CONTINUE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // Character codes.
  localparam logic [CH_W-1:0] CH_PERIOD   = 8'h2E;
  localparam logic [CH_W-1:0] CH_QUESTION = 8'h3F;
  localparam logic [CH_W-1:0] CH_EXCLAIM  = 8'h21;
  localparam logic [CH_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CH_W-1:0] CH_NEWLINE  = 8'h0A;
  localparam logic [CH_W-1:0] CH_TAB      = 8'h09;

  typedef struct packed {
    logic [INDEX_W-1:0] sentence_index;
    logic [CAP_W-1:0]   out_capacity;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]     out_byte;
    logic                has_byte;
    logic [STATUS_W-1:0] status;
    logic                done_res;
  } result_t;

endpackage

// ----- src/ssx_if.sv -----
// Handshake channel interfaces of the sentence select and extract unit.
// Depends on ssx_pkg for field widths.
interface ssx_in_if;
  logic                       valid;
  logic                       ready;
  logic [ssx_pkg::CH_W-1:0]   ch;
  logic                       last;
  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface ssx_out_if;
  logic                           valid;
  logic                           ready;
  logic [ssx_pkg::CH_W-1:0]       out_byte;
  logic                           has_byte;
  logic [ssx_pkg::STATUS_W-1:0]   status;
  logic                           done_res;
  modport source (output valid, output out_byte, output has_byte, output status,
                  output done_res, input ready);
  modport sink (input valid, input out_byte, input has_byte, input status,
                input done_res, output ready);
endinterface

interface ssx_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ssx_pkg::CFG_ADDR_W-1:0]   index;
  logic [ssx_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/ssx_cfg_regs.sv -----
// Configuration register file: sentence index and output capacity.
// Depends on ssx_pkg and the ssx_cfg_if interface.
module ssx_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  ssx_cfg_if.sink         cfg_i,
  output ssx_pkg::cfg_t   cfg_o
);

  ssx_pkg::cfg_t cfg_q;
  logic          wr_en;

  // The user must write only while the unit is idle; the block does not enforce this. The port never stalls.
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid & cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sentence_index <= ssx_pkg::INDEX_RESET;
      cfg_q.out_capacity   <= ssx_pkg::CAP_RESET;
    end else if (wr_en) begin
      case (cfg_i.index)
        ssx_pkg::REG_SENTENCE_INDEX: begin
          cfg_q.sentence_index <= cfg_i.data[ssx_pkg::INDEX_W-1:0];
        end
        ssx_pkg::REG_OUT_CAPACITY: begin
          cfg_q.out_capacity <= cfg_i.data[ssx_pkg::CAP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/ssx_engine.sv -----
// Sentence tracking engine: phase, stop flag, sentence and length counters,
// plus the per-byte decision logic. Depends on ssx_pkg.
module ssx_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [ssx_pkg::CH_W-1:0]   ch_i,
  input  logic                       last_i,
  input  ssx_pkg::cfg_t              cfg_i,
  output logic                       res_valid_o,
  output ssx_pkg::result_t           res_o
);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SENT,
    PH_DRAIN
  } phase_e;

  localparam logic [ssx_pkg::COUNT_WIDTH-1:0]  COUNT_MAX = '1;
  localparam logic [ssx_pkg::LENGTH_WIDTH-1:0] LEN_MAX   = '1;

  phase_e                             phase_q, phase_d;
  logic                               stop_q, stop_d;
  logic [ssx_pkg::COUNT_WIDTH-1:0]    count_q, count_d;
  logic [ssx_pkg::LENGTH_WIDTH-1:0]   emitted_q, emitted_d;

  logic                               is_space, is_stop, selected, emit;
  logic [ssx_pkg::LIMIT_W-1:0]        cap_ext, limit_raw, limit, len_max_ext;
  logic [ssx_pkg::LENGTH_WIDTH-1:0]   em_base;

  assign is_space = (ch_i == ssx_pkg::CH_SPACE) || (ch_i == ssx_pkg::CH_NEWLINE) ||
                    (ch_i == ssx_pkg::CH_TAB);
  assign is_stop  = (ch_i == ssx_pkg::CH_PERIOD) || (ch_i == ssx_pkg::CH_QUESTION) ||
                    (ch_i == ssx_pkg::CH_EXCLAIM);

  assign selected = ssx_pkg::SEL_W'(count_q) == ssx_pkg::SEL_W'(cfg_i.sentence_index);

  // Emission limit is capacity minus one (zero for capacity zero), capped by the length counter range.
  assign cap_ext     = ssx_pkg::LIMIT_W'(cfg_i.out_capacity);
  assign limit_raw   = (cfg_i.out_capacity == '0) ? '0 : cap_ext - 1'b1;
  assign len_max_ext = ssx_pkg::LIMIT_W'(LEN_MAX);
  assign limit       = (limit_raw > len_max_ext) ? len_max_ext : limit_raw;

  // A sentence starting on this byte counts from zero emitted bytes.
  assign em_base = (phase_q == PH_SKIP) ? '0 : emitted_q;
  assign emit    = selected && (ssx_pkg::LIMIT_W'(em_base) < limit);

  always_comb begin
    phase_d     = phase_q;
    stop_d      = stop_q;
    count_d     = count_q;
    emitted_d   = emitted_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      case (phase_q)
        PH_DRAIN: begin
          if (last_i) begin
            phase_d   = PH_SKIP;
            stop_d    = 1'b0;
            count_d   = '0;
            emitted_d = '0;
          end
        end
        default: begin
          if ((phase_q == PH_SKIP) && is_space) begin
            if (last_i) begin
              phase_d      = PH_SKIP;
              stop_d       = 1'b0;
              count_d      = '0;
              emitted_d    = '0;
              res_valid_o  = 1'b1;
              res_o.status = ssx_pkg::STATUS_NOT_FOUND;
              res_o.done_res = 1'b1;
            end
          end else if ((phase_q == PH_SENT) && stop_q && is_space) begin
            // The stop on the previous byte closed the sentence.
            stop_d         = 1'b0;
            res_o.done_res = 1'b1;
            if (selected) begin
              res_valid_o  = 1'b1;
              res_o.status = ssx_pkg::STATUS_FOUND;
              phase_d      = PH_DRAIN;
            end else begin
              phase_d      = PH_SKIP;
              count_d      = (count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
              res_valid_o  = last_i;
              res_o.status = ssx_pkg::STATUS_NOT_FOUND;
            end
            if (last_i) begin
              phase_d   = PH_SKIP;
              count_d   = '0;
              emitted_d = '0;
            end
          end else begin
            // This byte belongs to the current sentence.
            phase_d   = PH_SENT;
            stop_d    = is_stop;
            emitted_d = ssx_pkg::LENGTH_WIDTH'(em_base + ssx_pkg::LENGTH_WIDTH'(emit));
            res_o.out_byte = emit ? ch_i : '0;
            res_o.has_byte = emit;
            if (last_i) begin
              phase_d        = PH_SKIP;
              stop_d         = 1'b0;
              count_d        = '0;
              emitted_d      = '0;
              res_valid_o    = 1'b1;
              res_o.status   = selected ? ssx_pkg::STATUS_FOUND : ssx_pkg::STATUS_NOT_FOUND;
              res_o.done_res = 1'b1;
            end else begin
              res_valid_o  = emit;
              res_o.status = ssx_pkg::STATUS_CONTINUE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SKIP;
      stop_q    <= 1'b0;
      count_q   <= '0;
      emitted_q <= '0;
    end else begin
      phase_q   <= phase_d;
      stop_q    <= stop_d;
      count_q   <= count_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

// ----- src/sentence_select_extract_unit.sv -----
// Sentence select and extract unit, top level; uses ssx_pkg, the ssx interfaces,
// ssx_cfg_regs, ssx_engine and the assertion macro header.
// An accepted word is held in the input register; its result word is written to the output register.
// Throughput: one input word per cycle while the output register is empty or being read.
// Reset (rst_ni, asynchronous, active low) empties both registers, rearms the engine and
// loads the register defaults: sentence index 0, output capacity 256.
`include "sentence_select_extract_unit_assert.svh"

module sentence_select_extract_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssx_cfg_if.sink     cfg_i,
  ssx_in_if.sink      in_i,
  ssx_out_if.source   out_o
);

  // The datapath is two registers deep. The input register holds one text byte;
  // the engine reads it together with the sentence state, and in the same cycle
  // the state advances and any result word is written to the output register.
  // The byte advances whenever the output register is empty or is being drained,
  // so one byte per cycle flows while the sink keeps up. Bytes that cause no
  // result simply update the state and leave the output register untouched.

  ssx_pkg::cfg_t                cfg;
  logic                         in_valid_q;
  logic [ssx_pkg::CH_W-1:0]     ch_q;
  logic                         last_q;
  logic                         in_take;
  logic                         out_free;
  logic                         step;
  logic                         res_valid;
  ssx_pkg::result_t             res;
  logic                         out_valid_q, out_valid_d;
  ssx_pkg::result_t             out_q;

  ssx_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // The output register can take a new word when it is empty or being read.
  assign out_free = !out_valid_q || out_o.ready;
  assign step     = in_valid_q && out_free;

  // The input register refills in the same cycle that its byte is processed.
  assign in_i.ready = !in_valid_q || step;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q   <= in_i.ch;
      last_q <= in_i.last;
    end
  end

  ssx_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .ch_i        (ch_q),
    .last_i      (last_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // A processed byte either loads a result or leaves the register empty when the
  // old word has been read; otherwise the held word stays until it is read.
  always_comb begin
    if (step) begin
      out_valid_d = res_valid;
    end else begin
      out_valid_d = out_valid_q && !out_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_q.out_byte;
  assign out_o.has_byte = out_q.has_byte;
  assign out_o.status   = out_q.status;
  assign out_o.done_res = out_q.done_res;

  // A word that is not final always carries a sentence byte with status continue.
  `SSX_ASSERT(a_mid_word_has_byte, clk_i, rst_ni, (out_valid_q && !out_q.done_res) |-> (out_q.has_byte && (out_q.status == ssx_pkg::STATUS_CONTINUE)))
  // A final word reports found or not found, never continue.
  `SSX_ASSERT(a_final_has_outcome, clk_i, rst_ni, (out_valid_q && out_q.done_res) |-> ((out_q.status == ssx_pkg::STATUS_FOUND) || (out_q.status == ssx_pkg::STATUS_NOT_FOUND)))
  // Without a sentence byte the byte field is zero.
  `SSX_ASSERT_NEVER(a_byte_without_flag, clk_i, rst_ni, out_valid_q && !out_q.has_byte && (out_q.out_byte != '0))
  // A byte held back by a full output register stays in the input register.
  `SSX_ASSERT(a_input_held, clk_i, rst_ni, (in_valid_q && !step) |=> (in_valid_q && $stable(ch_q) && $stable(last_q)))

endmodule

// ----- dv/sentence_select_extract_unit_tb.sv -----
// Self-checking testbench for sentence_select_extract_unit: drives text words, writes both
// registers and checks every result word against a built-in sentence tracker.
// Depends on ssx_pkg, the ssx interfaces and the unit's RTL.
module sentence_select_extract_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 7;
  // Idle time after the last expected result, to cover anything still in flight.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int LONG_HOLD     = 300;
  // Random words on top of the directed texts; together they come to about 2000 words.
  localparam int RANDOM_WORDS  = 1800;
  localparam int REPORT_LIMIT  = 20;
  localparam int unsigned LEN_MAX = (1 << ssx_pkg::LENGTH_WIDTH) - 1;
  // Far above a run in which every word waits out the longest receiver stall.
  localparam longint TIMEOUT_NS = 64'd8_000_000;

  typedef enum logic [1:0] {
    SCAN_GAP,
    IN_SENTENCE,
    DRAIN_TEXT
  } text_phase_e;

  // Tracks the sentence being read and predicts each result word of the unit.
  class sentence_tracker;
    logic [ssx_pkg::INDEX_W-1:0]      target_index;
    logic [ssx_pkg::CAP_W-1:0]        capacity;
    text_phase_e                      phase;
    bit                               stop_seen;
    logic [ssx_pkg::COUNT_WIDTH-1:0]  done_count;
    logic [ssx_pkg::LENGTH_WIDTH-1:0] emitted;
    ssx_pkg::result_t                 awaited[$];
    int unsigned                      faults = 0;
    int unsigned                      all_words = 0;
    int unsigned                      live_words = 0;
    int unsigned                      checked = 0;
    int unsigned                      bytes_out = 0;
    int unsigned                      found_cnt = 0;
    int unsigned                      missed_cnt = 0;

    function new();
      target_index = ssx_pkg::INDEX_RESET;
      capacity     = ssx_pkg::CAP_RESET;
      rearm();
    endfunction

    static function bit is_blank(logic [ssx_pkg::CH_W-1:0] c);
      return c == ssx_pkg::CH_SPACE || c == ssx_pkg::CH_TAB || c == ssx_pkg::CH_NEWLINE;
    endfunction

    static function bit is_stop(logic [ssx_pkg::CH_W-1:0] c);
      return c == ssx_pkg::CH_PERIOD || c == ssx_pkg::CH_QUESTION ||
             c == ssx_pkg::CH_EXCLAIM;
    endfunction

    function void rearm();
      phase      = SCAN_GAP;
      stop_seen  = 1'b0;
      done_count = '0;
      emitted    = '0;
    endfunction

    function void set_reg(logic [ssx_pkg::CFG_ADDR_W-1:0] idx,
                          logic [ssx_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        ssx_pkg::REG_SENTENCE_INDEX: target_index = value[ssx_pkg::INDEX_W-1:0];
        ssx_pkg::REG_OUT_CAPACITY:   capacity = value[ssx_pkg::CAP_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the tracker by one text word; returns 1 when the word yields a result.
    function bit advance(logic [ssx_pkg::CH_W-1:0] c, logic fin, output ssx_pkg::result_t r);
      int unsigned limit;
      bit          selected;
      bit          emit;
      r        = '0;
      limit    = (capacity == 0) ? 0 : capacity - 1;
      if (limit > LEN_MAX) limit = LEN_MAX;
      selected = (done_count == target_index);
      emit     = 1'b0;
      if (phase == DRAIN_TEXT) begin
        if (fin) rearm();
        return 1'b0;
      end
      if (phase == SCAN_GAP) begin
        if (is_blank(c)) begin
          if (!fin) return 1'b0;
          rearm();
          r.status   = ssx_pkg::STATUS_NOT_FOUND;
          r.done_res = 1'b1;
          return 1'b1;
        end
        phase     = IN_SENTENCE;
        stop_seen = 1'b0;
        emitted   = '0;
      end else if (stop_seen && is_blank(c)) begin
        // The stop just before this blank closed the sentence.
        stop_seen = 1'b0;
        if (selected) begin
          if (fin) rearm();
          else phase = DRAIN_TEXT;
          r.status   = ssx_pkg::STATUS_FOUND;
          r.done_res = 1'b1;
          return 1'b1;
        end
        if (done_count != '1) done_count++;
        phase = SCAN_GAP;
        if (!fin) return 1'b0;
        rearm();
        r.status   = ssx_pkg::STATUS_NOT_FOUND;
        r.done_res = 1'b1;
        return 1'b1;
      end
      if (selected && emitted < limit) begin
        emitted++;
        emit = 1'b1;
      end
      stop_seen = is_stop(c);
      if (emit) begin
        r.out_byte = c;
        r.has_byte = 1'b1;
      end
      if (fin) begin
        rearm();
        r.status   = selected ? ssx_pkg::STATUS_FOUND : ssx_pkg::STATUS_NOT_FOUND;
        r.done_res = 1'b1;
        return 1'b1;
      end
      r.status = ssx_pkg::STATUS_CONTINUE;
      return emit;
    endfunction

    function void note_word(logic [ssx_pkg::CH_W-1:0] c, logic fin);
      ssx_pkg::result_t r;
      all_words++;
      if (phase != DRAIN_TEXT) live_words++;
      if (advance(c, fin, r)) awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [ssx_pkg::CH_W-1:0] want,
                                logic [ssx_pkg::CH_W-1:0] got);
      if (want !== got) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(ssx_pkg::result_t got);
      ssx_pkg::result_t want;
      if (awaited.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("%0t: result word with nothing expected, expected none, actual %0h/%0b/%0d/%0b",
                   $time, got.out_byte, got.has_byte, got.status, got.done_res);
        return;
      end
      want = awaited.pop_front();
      checked++;
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("has_byte", ssx_pkg::CH_W'(want.has_byte), ssx_pkg::CH_W'(got.has_byte));
      compare_field("status", ssx_pkg::CH_W'(want.status), ssx_pkg::CH_W'(got.status));
      compare_field("done_res", ssx_pkg::CH_W'(want.done_res), ssx_pkg::CH_W'(got.done_res));
      if (got.has_byte === 1'b1) bytes_out++;
      if (got.status === ssx_pkg::STATUS_FOUND && got.done_res === 1'b1) found_cnt++;
      if (got.status === ssx_pkg::STATUS_NOT_FOUND) missed_cnt++;
    endfunction

    function void report_leftovers();
      if (awaited.size() != 0) begin
        faults += awaited.size();
        $display("%0t: %0d result words never arrived, oldest expected status %0d, actual none",
                 $time, awaited.size(), awaited[0].status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ssx_cfg_if cfg_if ();
  ssx_in_if  in_if ();
  ssx_out_if out_if ();

  sentence_select_extract_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sentence_tracker tracker = new();

  logic [ssx_pkg::CH_W-1:0] text_buf[$];
  int unsigned              texts_sent = 0;
  int unsigned              reg_writes = 0;
  // no_idle turns off the random gaps on both sides; hold_off_request asks the
  // receiver for one long stall.
  bit                       no_idle = 1'b0;
  bit                       hold_off_request = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly short pauses, now and then a long one.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic int sender_gap();
    if (no_idle || $urandom_range(0, 99) < 50) return 0;
    return pause_len();
  endfunction

  // The receiver alternates runs of ready with stalls of random length. A long hold-off is
  // counted here, in cycles, while the sender keeps offering words.
  initial begin : receiver
    int span;
    bit level;
    out_if.ready = 1'b0;
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        repeat (LONG_HOLD) @(negedge clk) out_if.ready <= 1'b0;
      end else if (no_idle) begin
        @(negedge clk) out_if.ready <= 1'b1;
      end else begin
        level = ($urandom_range(0, 99) < 60);
        span  = level ? $urandom_range(1, 16) : pause_len();
        repeat (span) @(negedge clk) out_if.ready <= level;
      end
    end
  end

  // Both channels are observed at the rising edge. An input word is always noted before
  // the result words of the same edge are checked.
  always @(posedge clk) begin : watch_ports
    ssx_pkg::result_t got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) tracker.note_word(in_if.ch, in_if.last);
      if (out_if.valid && out_if.ready) begin
        got.out_byte = out_if.out_byte;
        got.has_byte = out_if.has_byte;
        got.status   = out_if.status;
        got.done_res = out_if.done_res;
        tracker.check_word(got);
      end
    end
  end

  // Keeps the input channel idle, driving valid low at the falling edge.
  task automatic hold_input(input int n);
    repeat (n) @(negedge clk) in_if.valid <= 1'b0;
  endtask

  // Offers one word and returns at the edge where it is taken.
  task automatic send_word(input logic [ssx_pkg::CH_W-1:0] c, input logic fin);
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    in_if.last  <= fin;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  // Sends the staged text; the final word carries last only when the text ends here.
  task automatic send_text(input bit ends_text);
    foreach (text_buf[i]) begin
      hold_input(sender_gap());
      send_word(text_buf[i], ends_text && i == text_buf.size() - 1);
    end
    if (ends_text) texts_sent++;
  endtask

  // Pauses the sender until every expected result word has come, then lets the pipeline
  // run empty, so that the registers may be written.
  task automatic settle_block();
    int waited;
    waited = 0;
    do begin
      hold_input(1);
      waited++;
    end while (tracker.awaited.size() != 0 && waited < DRAIN_LIMIT);
    hold_input(SETTLE_CYCLES);
  endtask

  task automatic write_reg(input logic [ssx_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [ssx_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    tracker.set_reg(idx, value);
    reg_writes++;
    @(negedge clk) cfg_if.valid <= 1'b0;
  endtask

  task automatic stage_string(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  function automatic logic [ssx_pkg::CH_W-1:0] pick_blank();
    case ($urandom_range(0, 2))
      0:       return ssx_pkg::CH_SPACE;
      1:       return ssx_pkg::CH_TAB;
      default: return ssx_pkg::CH_NEWLINE;
    endcase
  endfunction

  function automatic logic [ssx_pkg::CH_W-1:0] pick_stop();
    case ($urandom_range(0, 2))
      0:       return ssx_pkg::CH_PERIOD;
      1:       return ssx_pkg::CH_QUESTION;
      default: return ssx_pkg::CH_EXCLAIM;
    endcase
  endfunction

  // A sentence byte: mostly letters, sometimes any non-blank value from 1 to 255.
  function automatic logic [ssx_pkg::CH_W-1:0] pick_ink();
    logic [ssx_pkg::CH_W-1:0] c;
    if ($urandom_range(0, 99) < 75) return ssx_pkg::CH_W'("a" + $urandom_range(0, 25));
    do c = ssx_pkg::CH_W'($urandom_range(1, 255)); while (sentence_tracker::is_blank(c));
    return c;
  endfunction

  task automatic add_blanks(input int n);
    repeat (n) text_buf.push_back(pick_blank());
  endtask

  // Inner stops followed by a letter, as in "3.5", must not close the sentence.
  task automatic add_sentence(input bit with_stop);
    repeat ($urandom_range(1, 10)) begin
      text_buf.push_back(pick_ink());
      if ($urandom_range(0, 99) < 8) text_buf.push_back(pick_stop());
    end
    if (with_stop) begin
      text_buf.push_back(pick_stop());
      if ($urandom_range(0, 99) < 10) text_buf.push_back(pick_stop());
    end
  endtask

  // Stages a random text: mostly well-formed sentences with random content, otherwise
  // blank-only texts or raw noise.
  task automatic compose_text();
    int r;
    int count;
    int ending;
    text_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 12) begin
      repeat ($urandom_range(1, 24)) begin
        case ($urandom_range(0, 6))
          0, 1:    text_buf.push_back(pick_blank());
          2:       text_buf.push_back(pick_stop());
          default: text_buf.push_back(ssx_pkg::CH_W'($urandom_range(1, 255)));
        endcase
      end
    end else if (r < 18) begin
      add_blanks($urandom_range(1, 4));
    end else begin
      if ($urandom_range(0, 99) < 30) add_blanks($urandom_range(1, 2));
      count  = $urandom_range(1, 6);
      ending = $urandom_range(0, 3);
      for (int s = 0; s < count; s++) begin
        if (s < count - 1) begin
          add_sentence(1'b1);
          add_blanks($urandom_range(1, 3));
        end else begin
          add_sentence(ending != 1 && ending != 3);
          if (ending >= 2) add_blanks($urandom_range(1, 2));
        end
      end
    end
  endtask

  function automatic logic [ssx_pkg::CFG_DATA_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return ssx_pkg::CFG_DATA_W'($urandom_range(0, 3));
    if (r < 90) return ssx_pkg::CFG_DATA_W'($urandom_range(4, 12));
    return ssx_pkg::CFG_DATA_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [ssx_pkg::CFG_DATA_W-1:0] pick_capacity();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return ssx_pkg::CFG_DATA_W'($urandom_range(1, 6));
    if (r < 70) return ssx_pkg::CFG_DATA_W'($urandom_range(7, 64));
    if (r < 85) return ssx_pkg::CFG_DATA_W'(ssx_pkg::CAP_RESET);
    if (r < 95) return ssx_pkg::CFG_DATA_W'($urandom_range(0, 4096));
    return ($urandom_range(0, 1) != 0) ? 16'd4096 : 16'd0;
  endfunction

  initial begin : stimulus
    int base;
    in_if.valid  = 1'b0;
    in_if.ch     = '0;
    in_if.last   = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = ssx_pkg::REG_SENTENCE_INDEX;
    cfg_if.data  = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    hold_input(2);

    // Directed texts with the reset settings (sentence 0, capacity 256). The first is
    // found before its end, so the tail after the closing blank yields nothing.
    stage_string(" \t\nHi! x");
    send_text(1'b1);
    // A text made only of a blank is not found on its final word.
    stage_string(" ");
    send_text(1'b1);
    // Byte extremes inside a sentence that closes on the final word.
    text_buf.delete();
    text_buf.push_back(8'h01);
    text_buf.push_back(8'hFF);
    text_buf.push_back(ssx_pkg::CH_PERIOD);
    send_text(1'b1);
    stage_string("Ok? No");
    send_text(1'b1);

    // Capacity one emits nothing, even for the selected sentence.
    settle_block();
    write_reg(ssx_pkg::REG_OUT_CAPACITY, 16'd1);
    write_reg(ssx_pkg::REG_SENTENCE_INDEX, 16'd1);
    stage_string("a. bc");
    send_text(1'b1);

    // Capacity zero behaves like capacity one.
    settle_block();
    write_reg(ssx_pkg::REG_OUT_CAPACITY, 16'd0);
    write_reg(ssx_pkg::REG_SENTENCE_INDEX, 16'd0);
    stage_string("z");
    send_text(1'b1);

    // Register write in the middle of a text: it applies from the next word on.
    settle_block();
    write_reg(ssx_pkg::REG_OUT_CAPACITY, 16'd3);
    write_reg(ssx_pkg::REG_SENTENCE_INDEX, 16'd5);
    stage_string("a. ");
    send_text(1'b0);
    settle_block();
    write_reg(ssx_pkg::REG_SENTENCE_INDEX, 16'd1);
    stage_string("bcd!");
    send_text(1'b1);

    // Back pressure: the receiver stalls for a long stretch while a long selected
    // sentence keeps coming, so the unit fills up and holds its input off.
    settle_block();
    write_reg(ssx_pkg::REG_SENTENCE_INDEX, 16'd0);
    write_reg(ssx_pkg::REG_OUT_CAPACITY, ssx_pkg::CFG_DATA_W'(ssx_pkg::CAP_RESET));
    text_buf.delete();
    repeat (120) text_buf.push_back(pick_ink());
    text_buf.push_back(ssx_pkg::CH_EXCLAIM);
    hold_off_request = 1'b1;
    send_text(1'b1);

    // Capacity 4096 with words back to back: the whole sentence comes out.
    settle_block();
    no_idle = 1'b1;
    write_reg(ssx_pkg::REG_OUT_CAPACITY, 16'd4096);
    text_buf.delete();
    repeat (40) text_buf.push_back("x");
    send_text(1'b1);

    // Highest sentence index: a short text never reaches it.
    settle_block();
    write_reg(ssx_pkg::REG_SENTENCE_INDEX, 16'hFFFF);
    write_reg(ssx_pkg::REG_OUT_CAPACITY, 16'd2);
    stage_string("a. b.");
    send_text(1'b1);
    settle_block();
    no_idle = 1'b0;

    // Random texts in groups, each group under fresh register settings; now and then the
    // sender waits for every result between texts.
    base = tracker.all_words;
    while (tracker.all_words - base < RANDOM_WORDS) begin
      settle_block();
      write_reg(ssx_pkg::REG_SENTENCE_INDEX, pick_index());
      write_reg(ssx_pkg::REG_OUT_CAPACITY, pick_capacity());
      no_idle = ($urandom_range(0, 9) == 0);
      repeat ($urandom_range(4, 10)) begin
        compose_text();
        send_text(1'b1);
        if ($urandom_range(0, 9) == 0) settle_block();
      end
    end
    no_idle = 1'b0;

    settle_block();
    tracker.report_leftovers();
    $display("Ran %0d texts, %0d words accepted (%0d outside drained tails), %0d register writes.",
             texts_sent, tracker.all_words, tracker.live_words, reg_writes);
    $display("Checked %0d result words: %0d sentence bytes, %0d found, %0d not found.",
             tracker.checked, tracker.bytes_out, tracker.found_cnt, tracker.missed_cnt);
    if (tracker.faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("%0t: run did not finish in time", $time);
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sentence_select_extract_unit.f -----
+incdir+src
src/ssx_pkg.sv
src/ssx_if.sv
src/ssx_cfg_regs.sv
src/ssx_engine.sv
src/sentence_select_extract_unit.sv
dv/sentence_select_extract_unit_tb.sv
